// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Each macro takes a label, the clock, the active-low reset, the expressions
// and a message string.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NMIT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NMIT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition that must never hold
`define NMIT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== src/nmit_pkg.sv =====
// ----------------------------------------------------------------------------
// nmit_pkg
// Shared types and constants of the nearest marked index tree.
// ----------------------------------------------------------------------------
package nmit_pkg;

    localparam int POS_W   = 11;
    localparam int POS_MAX = (1 << POS_W) - 1;

    localparam logic [POS_W-1:0] LIMIT_RESET = 11'd1024;

    typedef logic [POS_W-1:0] pos_t;

    typedef enum logic
    {
        CMD_QUERY = 1'b0,
        CMD_MARK  = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // one tree node: greatest and least marked position below it, 0 = none
    typedef struct packed
    {
        pos_t max_pos;
        pos_t min_pos;
    } node_t;

    // running neighbor candidates of a query, 0 = none yet
    typedef struct packed
    {
        pos_t below;
        pos_t above;
    } cand_t;

    // control for the node unit
    typedef struct packed
    {
        cmd_t cmd;
        logic right;   // path node is a right child, so sibling lies below
        pos_t pos;
    } step_t;

    typedef struct packed
    {
        logic index_valid;
        logic below_found;
        pos_t below_index;
        logic above_found;
        pos_t above_index;
    } result_t;

endpackage

// ===== src/nmit_if.sv =====
// ----------------------------------------------------------------------------
// nmit_if
// Valid/ready stream interfaces for request and response beats.
// ----------------------------------------------------------------------------
interface nmit_cmd_if;
    logic          valid;
    logic          ready;
    logic          cmd;
    logic          set_select;
    nmit_pkg::pos_t position;

    modport source (output valid, cmd, set_select, position, input ready);
    modport sink   (input valid, cmd, set_select, position, output ready);
endinterface

interface nmit_rsp_if;
    logic           valid;
    logic           ready;
    logic           index_valid;
    logic           below_found;
    nmit_pkg::pos_t below_index;
    logic           above_found;
    nmit_pkg::pos_t above_index;

    modport source (output valid, index_valid, below_found, below_index,
                    above_found, above_index, input ready);
    modport sink   (input valid, index_valid, below_found, below_index,
                    above_found, above_index, output ready);
endinterface

// ===== src/nmit_ram.sv =====
// ----------------------------------------------------------------------------
// nmit_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nmit_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/nmit_node_unit.sv =====
// ----------------------------------------------------------------------------
// nmit_node_unit
// Shared compare unit: folds a mark into a node, or a sibling into the
// running neighbor candidates of a query.
// ----------------------------------------------------------------------------
module nmit_node_unit (
    input  nmit_pkg::step_t step,
    input  nmit_pkg::node_t node,
    input  nmit_pkg::cand_t cand,
    output nmit_pkg::node_t node_upd,
    output nmit_pkg::cand_t cand_upd
);

    // least of two, 0 meaning empty
    function automatic nmit_pkg::pos_t min_present(nmit_pkg::pos_t a, nmit_pkg::pos_t b);
        nmit_pkg::pos_t r;
        if (a == '0)
        begin
            r = b;
        end
        else if (b == '0)
        begin
            r = a;
        end
        else
        begin
            r = (a < b) ? a : b;
        end
        return r;
    endfunction

    always_comb
    begin
        node_upd.max_pos = (node.max_pos > step.pos) ? node.max_pos : step.pos;
        node_upd.min_pos = min_present(node.min_pos, step.pos);
    end

    always_comb
    begin
        cand_upd = cand;
        if (step.cmd == nmit_pkg::CMD_QUERY)
        begin
            if (step.right)
            begin
                cand_upd.below = (node.max_pos > cand.below) ? node.max_pos : cand.below;
            end
            else
            begin
                cand_upd.above = min_present(cand.above, node.min_pos);
            end
        end
    end

endmodule

// ===== src/nearest_marked_index_tree.sv =====
// ----------------------------------------------------------------------------
// nearest_marked_index_tree
// One item at a time: a request is taken only in idle, once the previous
//   result is loaded; a mark or query walks the tree (L = clog2(min(MAX_POSITIONS,
//   2047)), 10 by default) with one node read per cycle through the tree RAM's
//   single read port, and an out-of-range request skips the walk.
// Reset: sets cleared by a sweep over all 2**(SET_W+L+1) tree RAM entries (4096
//   by default), no request taken meanwhile; the positions limit resets to 1024.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_marked_index_tree #(
    parameter int MAX_POSITIONS = 1024,
    parameter int NUM_SETS      = 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  nmit_pkg::pos_t           cfg_data,
    nmit_cmd_if.sink                 req,
    nmit_rsp_if.source               rsp
);

    // positions beyond the field's range can never be named, so the tree
    // stops there
    localparam int CAP       = (MAX_POSITIONS > nmit_pkg::POS_MAX) ?
                               nmit_pkg::POS_MAX : MAX_POSITIONS;
    localparam int LEVELS    = $clog2(CAP);
    localparam int NODE_W    = LEVELS + 1;
    localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int ADDR_W    = SET_W + NODE_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int DEPTH_W   = $clog2(LEVELS + 1);
    localparam int NODE_BITS = 2 * nmit_pkg::POS_W;

    localparam nmit_pkg::pos_t     LIMIT_CAP  = nmit_pkg::POS_W'(CAP);
    localparam logic [DEPTH_W-1:0] LAST_DEPTH = DEPTH_W'(LEVELS);

    nmit_pkg::state_t state_reg, state_next;

    // config
    nmit_pkg::pos_t limit_reg;
    nmit_pkg::pos_t limit;

    // item context
    nmit_pkg::cmd_t      mark_reg;
    logic                item_valid_reg;
    logic [SET_W-1:0]    set_reg;
    nmit_pkg::pos_t      pos_reg;
    logic [LEVELS-1:0]   leaf_reg;
    logic [NODE_W-1:0]   path_reg;
    logic [DEPTH_W-1:0]  depth_reg;
    nmit_pkg::cand_t     cand_reg;

    // clear sweep
    logic [ADDR_W-1:0]   clr_reg;

    // read data stage
    logic                dvalid_reg;
    logic [ADDR_W-1:0]   daddr_reg;
    logic                dright_reg;

    // result register
    logic                out_valid_reg;
    nmit_pkg::result_t   res_reg;
    nmit_pkg::result_t   res_new;

    // FSM outputs
    logic                accept;
    logic                issue;
    logic                load;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [NODE_BITS-1:0] ram_wdata;

    // request decode
    logic                req_ok;
    nmit_pkg::pos_t      pos_m1;
    logic [LEVELS-1:0]   leaf_in;

    logic [NODE_W-1:0]   node_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic [NODE_BITS-1:0] rd_data;

    nmit_pkg::step_t     step;
    nmit_pkg::node_t     node_upd;
    nmit_pkg::cand_t     cand_upd;

    // ---------------------------------------------------------------- decode
    assign limit   = (limit_reg < LIMIT_CAP) ? limit_reg : LIMIT_CAP;
    assign req_ok  = (req.position != '0) && (req.position <= limit) &&
                     (32'(req.set_select) < NUM_SETS);
    assign pos_m1  = req.position - nmit_pkg::pos_t'(1);
    assign leaf_in = pos_m1[LEVELS-1:0];
    assign accept  = req.valid && req.ready;

    // a mark walks root to leaf along the path; a query reads the sibling
    // of each path node below the root
    assign node_addr = (mark_reg == nmit_pkg::CMD_MARK) ? path_reg
                                                        : (path_reg ^ NODE_W'(1));
    assign rd_addr   = {set_reg, node_addr};

    // ------------------------------------------------------------ next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nmit_pkg::ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = nmit_pkg::ST_IDLE;
                end
            end
            nmit_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = req_ok ? nmit_pkg::ST_WALK : nmit_pkg::ST_FINISH;
                end
            end
            nmit_pkg::ST_WALK:
            begin
                if (depth_reg == LAST_DEPTH)
                begin
                    state_next = nmit_pkg::ST_DRAIN;
                end
            end
            nmit_pkg::ST_DRAIN:
            begin
                state_next = nmit_pkg::ST_FINISH;
            end
            nmit_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = nmit_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nmit_pkg::ST_CLEAR;
            end
        endcase
    end

    // ----------------------------------------------------------- FSM outputs
    always_comb
    begin
        req.ready = 1'b0;
        issue     = 1'b0;
        load      = 1'b0;
        ram_we    = dvalid_reg && (mark_reg == nmit_pkg::CMD_MARK);
        ram_waddr = daddr_reg;
        ram_wdata = node_upd;
        case (state_reg)
            nmit_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            nmit_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            nmit_pkg::ST_WALK:
            begin
                issue = 1'b1;
            end
            nmit_pkg::ST_DRAIN:
            begin
                issue = 1'b0;
            end
            nmit_pkg::ST_FINISH:
            begin
                load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------- node unit
    assign step = '{cmd: mark_reg, right: dright_reg, pos: pos_reg};

    nmit_node_unit u_node_unit (
        .step     (step),
        .node     (nmit_pkg::node_t'(rd_data)),
        .cand     (cand_reg),
        .node_upd (node_upd),
        .cand_upd (cand_upd)
    );

    nmit_ram #(
        .WIDTH (NODE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_tree_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ---------------------------------------------------------------- result
    always_comb
    begin
        res_new             = '0;
        res_new.index_valid = item_valid_reg;
        if (item_valid_reg && (mark_reg == nmit_pkg::CMD_QUERY))
        begin
            res_new.below_found = (cand_reg.below != '0);
            res_new.below_index = cand_reg.below;
            // marks left above a lowered limit do not count
            if ((cand_reg.above != '0) && (cand_reg.above <= limit))
            begin
                res_new.above_found = 1'b1;
                res_new.above_index = cand_reg.above;
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.index_valid = res_reg.index_valid;
    assign rsp.below_found = res_reg.below_found;
    assign rsp.below_index = res_reg.below_index;
    assign rsp.above_found = res_reg.above_found;
    assign rsp.above_index = res_reg.above_index;

    // ------------------------------------------------------ control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nmit_pkg::ST_CLEAR;
            limit_reg     <= nmit_pkg::LIMIT_RESET;
            clr_reg       <= '0;
            depth_reg     <= '0;
            dvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            dvalid_reg <= issue;
            if (cfg_write)
            begin
                limit_reg <= cfg_data;
            end
            if (state_reg == nmit_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (accept)
            begin
                depth_reg <= (req.cmd == nmit_pkg::CMD_MARK) ? '0 : DEPTH_W'(1);
            end
            else if (issue)
            begin
                depth_reg <= depth_reg + DEPTH_W'(1);
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------ payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mark_reg       <= nmit_pkg::cmd_t'(req.cmd);
            item_valid_reg <= req_ok;
            set_reg        <= SET_W'(req.set_select);
            pos_reg        <= req.position;
            cand_reg       <= '0;
            if (req.cmd == nmit_pkg::CMD_MARK)
            begin
                path_reg <= NODE_W'(1);
                leaf_reg <= leaf_in;
            end
            else
            begin
                path_reg <= NODE_W'({1'b1, leaf_in[LEVELS-1]});
                leaf_reg <= leaf_in << 1;
            end
        end
        else
        begin
            if (issue)
            begin
                path_reg <= {path_reg[NODE_W-2:0], leaf_reg[LEVELS-1]};
                leaf_reg <= leaf_reg << 1;
            end
            if (dvalid_reg)
            begin
                cand_reg <= cand_upd;
            end
        end
        if (issue)
        begin
            daddr_reg  <= rd_addr;
            dright_reg <= path_reg[0];
        end
        if (load)
        begin
            res_reg <= res_new;
        end
    end

    // ------------------------------------------------------------ assertions
    `NMIT_ASSERT_IMPL(a_write_only_mark, clk, rst_n,
        ram_we && (state_reg != nmit_pkg::ST_CLEAR),
        (mark_reg == nmit_pkg::CMD_MARK) && item_valid_reg,
        "tree written outside clear sweep or valid mark")
    `NMIT_ASSERT_NEXT(a_below_order, clk, rst_n, load,
        !res_reg.below_found || (res_reg.below_index < pos_reg),
        "below neighbor not below position")
    `NMIT_ASSERT_NEXT(a_above_order, clk, rst_n, load,
        !res_reg.above_found ||
        ((res_reg.above_index > pos_reg) && (res_reg.above_index <= limit)),
        "above neighbor out of range")
    `NMIT_ASSERT_NEVER(a_found_invalid, clk, rst_n,
        out_valid_reg && !res_reg.index_valid &&
        (res_reg.below_found || res_reg.above_found),
        "neighbor found for invalid index")

endmodule

// ===== test/nearest_marked_index_tree_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_marked_index_tree_check
// Watches the request and response streams and the limit register port.
// Keeps a bitmap of marked positions per set, computes the answer for every
// accepted request, and compares each response beat field by field with the
// oldest answer still due.
// ----------------------------------------------------------------------------
module nearest_marked_index_tree_check
    import nmit_pkg::*;
#(
    parameter int TREE_SIZE = 1024
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  pos_t cfg_data,
    nmit_cmd_if  req,
    nmit_rsp_if  rsp,
    output int   fail_count,
    output int   expected_left
);

    bit [TREE_SIZE:1] marked [0:1];
    pos_t             limit_setting;
    result_t          answers_due [$];
    result_t          due;

    // nearest marked neighbors of a query, or the echo of a mark
    function automatic result_t resolve_beat(cmd_t op, logic which, pos_t where);
        result_t r;
        int      lim;
        int      p;
        int      k;
        r   = '0;
        p   = int'(where);
        lim = (limit_setting > TREE_SIZE) ? TREE_SIZE : int'(limit_setting);
        if (p < 1 || p > lim)
        begin
            return r;
        end
        r.index_valid = 1'b1;
        if (op == CMD_MARK)
        begin
            marked[which][p] = 1'b1;
            return r;
        end
        for (k = p - 1; k >= 1 && !r.below_found; k--)
        begin
            if (marked[which][k])
            begin
                r.below_found = 1'b1;
                r.below_index = pos_t'(k);
            end
        end
        // upward search stops at the current limit, marks beyond it stay hidden
        for (k = p + 1; k <= lim && !r.above_found; k++)
        begin
            if (marked[which][k])
            begin
                r.above_found = 1'b1;
                r.above_index = pos_t'(k);
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marked[0]     = '0;
            marked[1]     = '0;
            limit_setting = LIMIT_RESET;
            answers_due.delete();
            fail_count    = 0;
            expected_left = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("response beat with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    due = answers_due.pop_front();
                    check_field("index_valid", due.index_valid, rsp.index_valid);
                    check_field("below_found", due.below_found, rsp.below_found);
                    check_field("below_index", due.below_index, rsp.below_index);
                    check_field("above_found", due.above_found, rsp.above_found);
                    check_field("above_index", due.above_index, rsp.above_index);
                end
            end
            if (req.valid && req.ready)
            begin
                answers_due.insert(answers_due.size(),
                                   resolve_beat(cmd_t'(req.cmd), req.set_select,
                                                req.position));
            end
            if (cfg_write)
            begin
                limit_setting = cfg_data;
            end
            expected_left = answers_due.size();
        end
    end

endmodule

// ===== test/nearest_marked_index_tree_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_marked_index_tree_test
// Drives mark and query beats into the neighbor search tree, moves the
// positions limit between phases, and throttles both streams at random.
// The checker beside the block predicts and compares; this module makes the
// stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module nearest_marked_index_tree_test;
    import nmit_pkg::*;

    localparam int TREE_SIZE      = 1024;
    localparam int HOLD_CYCLES    = 300;    // long receiver stall, fills the block
    localparam int WATCHDOG_LIMIT = 20000;  // covers the clearing sweep over all 4096 tree entries
    localparam int DRAIN_CYCLES   = 30;     // quiet time after the last answer, before the verdict
    localparam int RANDOM_PHASES  = 10;

    // limit per random phase: full span, small spans, one position, zero,
    // and a value past the tree size (clamped to 1024 by the block)
    localparam int PHASE_LIMIT [RANDOM_PHASES] =
        '{1024, 40, 1, 1024, 2, 700, 2047, 0, 513, 1024};
    // the zero-limit phase only yields out-of-range beats, so it stays short
    localparam int PHASE_ITEMS [RANDOM_PHASES] =
        '{250, 150, 60, 250, 80, 250, 200, 30, 200, 280};

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cfg_write = 1'b0;
    pos_t cfg_data  = LIMIT_RESET;

    nmit_cmd_if req_if ();
    nmit_rsp_if rsp_if ();

    int   fail_count;
    int   expected_left;
    pos_t limit_now = LIMIT_RESET;  // mirror of what was last written
    bit   calm      = 1'b0;         // no idling on either side while set
    bit   hold_req  = 1'b0;         // asks the receiver for one long stall
    int   stall_cycles = 0;
    int   n_marks = 0;
    int   n_queries = 0;
    int   n_outside = 0;
    int   n_limits = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    nearest_marked_index_tree #(
        .MAX_POSITIONS (TREE_SIZE),
        .NUM_SETS      (2)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    nearest_marked_index_tree_check #(
        .TREE_SIZE (TREE_SIZE)
    ) result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .req           (req_if),
        .rsp           (rsp_if),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    // Watchdog: any accepted beat or register write restarts the count.
    // The limit is far above the clearing sweep plus the long hold.
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || cfg_write)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // highest valid position under the current limit
    function automatic int span();
        return (limit_now > TREE_SIZE) ? TREE_SIZE : int'(limit_now);
    endfunction

    // idle length: mostly none, often a few cycles, now and then a long gap
    function automatic int pick_gap();
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Position mix: mostly inside the span, weighted toward both ends,
    // plus zero, one past the limit, and raw 11-bit values so that every
    // bit of the field toggles.
    function automatic pos_t pick_position();
        int r;
        int lim;
        lim = span();
        r   = $urandom_range(0, 99);
        if (r < 4)
        begin
            return '0;
        end
        if (r < 9 || lim == 0)
        begin
            return pos_t'($urandom_range(0, POS_MAX));
        end
        if (r < 15)
        begin
            return pos_t'(1);
        end
        if (r < 21)
        begin
            return pos_t'(lim);
        end
        if (r < 25)
        begin
            return pos_t'(lim + 1);
        end
        return pos_t'($urandom_range(1, lim));
    endfunction

    // One request beat. Valid drops only for a gap; back-to-back beats keep
    // it high and just change the payload at the falling edge.
    task automatic send_beat(input cmd_t op, input logic which, input pos_t where);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_if.valid      <= 1'b1;
        req_if.cmd        <= op;
        req_if.set_select <= which;
        req_if.position   <= where;
        if (where < 1 || where > span())
        begin
            n_outside++;
        end
        else if (op == CMD_MARK)
        begin
            n_marks++;
        end
        else
        begin
            n_queries++;
        end
        // accepted at the first rising edge with ready high
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
    endtask

    // stop offering and wait until every answer has come back
    task automatic settle();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (expected_left != 0)
        begin
            @(negedge clk);
        end
    endtask

    // the register is only written with the block idle
    task automatic write_limit(input pos_t value);
        settle();
        cfg_write <= 1'b1;
        cfg_data  <= value;
        limit_now = value;
        n_limits++;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Response side: random backpressure, plus one long hold on request.
    initial
    begin : receiver
        int gap;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                gap = pick_gap();
                if (gap == 0)
                begin
                    rsp_if.ready <= 1'b1;
                end
                else
                begin
                    rsp_if.ready <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        int   ph;
        int   i;
        cmd_t op;
        req_if.valid      = 1'b0;
        req_if.cmd        = CMD_QUERY;
        req_if.set_select = 1'b0;
        req_if.position   = '0;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // --- directed: limit at its reset value of 1024 ---
        send_beat(CMD_QUERY, 1'b0, 11'd5);     // empty set, nothing found
        send_beat(CMD_MARK,  1'b0, 11'd1);     // lowest position
        send_beat(CMD_MARK,  1'b0, 11'd1024);  // highest position
        send_beat(CMD_MARK,  1'b0, 11'd512);
        send_beat(CMD_MARK,  1'b0, 11'd512);   // same position again
        send_beat(CMD_MARK,  1'b1, 11'd300);   // other set stays separate
        send_beat(CMD_QUERY, 1'b0, 11'd512);   // neighbors on both sides
        send_beat(CMD_QUERY, 1'b0, 11'd1);     // nothing can lie below 1
        send_beat(CMD_QUERY, 1'b0, 11'd1024);  // nothing can lie above the limit
        send_beat(CMD_QUERY, 1'b1, 11'd1);
        send_beat(CMD_QUERY, 1'b1, 11'd300);   // only itself marked
        send_beat(CMD_MARK,  1'b0, 11'd0);     // out of range: zero
        send_beat(CMD_QUERY, 1'b1, 11'd0);
        send_beat(CMD_MARK,  1'b1, 11'd1025);  // out of range: past the limit
        send_beat(CMD_QUERY, 1'b0, 11'd2047);

        // lowered limit: marks above it stay but are hidden from the upward search
        write_limit(11'd600);
        send_beat(CMD_QUERY, 1'b0, 11'd512);
        send_beat(CMD_QUERY, 1'b0, 11'd600);
        send_beat(CMD_MARK,  1'b0, 11'd601);

        // single position: valid, but no room for any neighbor
        write_limit(11'd1);
        send_beat(CMD_MARK,  1'b1, 11'd1);
        send_beat(CMD_QUERY, 1'b1, 11'd1);
        send_beat(CMD_QUERY, 1'b1, 11'd2);

        // zero limit: everything is out of range
        write_limit(11'd0);
        send_beat(CMD_QUERY, 1'b0, 11'd1);
        send_beat(CMD_MARK,  1'b1, 11'd1);

        // limit past the tree size is clamped to 1024
        write_limit(11'd2047);
        send_beat(CMD_QUERY, 1'b0, 11'd1023);
        send_beat(CMD_MARK,  1'b0, 11'd1025);

        // --- random phases, one limit each; marks persist across phases ---
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_limit(pos_t'(PHASE_LIMIT[ph]));
            calm = (ph == 5);
            for (i = 0; i < PHASE_ITEMS[ph]; i++)
            begin
                // receiver stalls long while this side keeps offering
                if (ph == 3 && i == 50)
                begin
                    hold_req = 1'b1;
                end
                op = ($urandom_range(0, 9) < 3) ? CMD_MARK : CMD_QUERY;
                send_beat(op, 1'($urandom_range(0, 1)), pick_position());
            end
        end

        calm = 1'b0;
        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d marks, %0d queries and %0d out-of-range beats on two sets",
                 n_marks, n_queries, n_outside);
        $display("Limit moved through %0d values, from 0 and 1 up past the tree size",
                 n_limits);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
